// ===== hw/rtl/periodic_sample_store_macros.svh =====
// Assertion macros for the periodic sample store.
// Used by the top level; no other dependencies.
`ifndef PERIODIC_SAMPLE_STORE_MACROS_SVH
`define PERIODIC_SAMPLE_STORE_MACROS_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define PSS_ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition");
`else
`define PSS_ASSERT(label, clk, rstn, prop)
`define PSS_ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/pss_pkg.sv =====
// Shared types and constants for the periodic sample store.
// No dependencies.
package pss_pkg;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PERIOD   = 3'd1;
  localparam logic [2:0] ST_PHASE    = 3'd2;
  localparam logic [2:0] ST_MISALIGN = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [31:0] MARKER_RESET = 32'hD8F1_0000;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic div_start;  // start offset division
    logic decide;     // evaluate outcome after division
    logic fill_step;  // write one gap slot
    logic final_wr;   // write the sample slot and commit
    logic rd_issue;   // issue RAM read
    logic rd_done;    // form read result
  } pss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic is_read;
    logic fill_left;  // more gap slots remain
    logic need_rd;    // read must fetch a RAM slot
    logic do_write;   // insert commits a write
  } pss_stat_t;
endpackage

// ===== hw/rtl/pss_if.sv =====
// Valid/ready channel interface with generic payload.
// Depends on nothing.
interface pss_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pss_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module pss_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/pss_div.sv =====
// Restoring divider, one quotient bit per cycle: 63-bit by 32-bit.
// No dependencies.
module pss_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [62:0] quot_o,
  output logic [31:0] rem_o
);
  logic [62:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[31:0], quot_q[62]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'd62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quot_d = {quot_q[61:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[61:0], 1'b0};
      end
      if (cnt_q == 6'd0) busy_d = 1'b0;
      else cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[31:0];
endmodule

// ===== hw/rtl/pss_datapath.sv =====
// Datapath: series registers, offset divider, sample RAM and result.
// Depends on pss_pkg, pss_div, pss_ram.
module pss_datapath
  import pss_pkg::*;
#(
  parameter int StoreDepth = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pss_cmd_t    cmd_i,
  output pss_stat_t   stat_o,
  input  logic [31:0] marker_i,
  input  logic        mode_i,
  input  logic [62:0] start_time_i,
  input  logic [31:0] span_length_i,
  input  logic [31:0] sample_value_i,
  input  logic        overwrite_enable_i,
  output logic [31:0] read_value_o,
  output logic        missing_flag_o,
  output logic [2:0]  status_o
);
  localparam int AW = $clog2(StoreDepth);
  localparam int CW = $clog2(StoreDepth + 1);
  localparam int SW = CW + 1;

  logic [31:0] period_q;
  logic [62:0] sstart_q;
  logic [AW-1:0] head_q;
  logic [CW-1:0] count_q;

  logic        mode_q, mode_d, ow_q, ow_d;
  logic [62:0] t_q, t_d;
  logic [31:0] span_q, span_d, val_q, val_d;

  // outcome registers
  logic [AW-1:0] fill_addr_q, fill_addr_d, wr_addr_q, wr_addr_d, rd_addr_q, rd_addr_d;
  logic [CW-1:0] fill_left_q, fill_left_d, new_count_q, new_count_d;
  logic [AW-1:0] new_head_q, new_head_d;
  logic [62:0]   new_start_q, new_start_d;
  logic          do_write_q, do_write_d, need_rd_q, need_rd_d;
  logic [31:0]   rv_q, rv_d;
  logic          flag_q, flag_d;
  logic [2:0]    st_q, st_d;

  // ring address a + b, b at most the depth
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(StoreDepth)) s = s - SW'(StoreDepth);
    return AW'(s);
  endfunction

  // ring address a - b, b at most the depth
  function automatic logic [AW-1:0] wrap_sub(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(StoreDepth) - SW'(b);
    if (s >= SW'(StoreDepth)) s = s - SW'(StoreDepth);
    return AW'(s);
  endfunction

  // end of series and unsigned distance
  logic [63:0] end_w;
  logic [62:0] dist_w;
  logic        t_ge_start;
  assign end_w = {1'b0, sstart_q} + 64'(count_q) * 64'(period_q);
  assign t_ge_start = t_q >= sstart_q;
  assign dist_w = t_ge_start ? t_q - sstart_q : sstart_q - t_q;

  logic        div_busy;
  logic [62:0] quot;
  logic [31:0] rem;
  pss_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(dist_w),
    .divisor_i(period_q), .busy_o(div_busy), .quot_o(quot), .rem_o(rem)
  );

  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [31:0]   ram_wd, ram_rd;
  assign ram_we = cmd_i.fill_step || (cmd_i.final_wr && do_write_q);
  assign ram_wa = cmd_i.fill_step ? fill_addr_q : wr_addr_q;
  assign ram_wd = cmd_i.fill_step ? marker_i : val_q;
  pss_ram #(.Width(32), .Depth(StoreDepth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(rd_addr_q), .rdata_o(ram_rd)
  );

  // decision terms (quotient is the slot distance)
  logic [CW-1:0] room;
  logic          q_small;   // quot fits below depth
  logic [CW-1:0] q_n;       // quot as count
  logic [CW-1:0] pre_n;     // gap slots for a prepend
  logic [AW-1:0] pre_head;  // head after a prepend
  assign room     = CW'(StoreDepth) - count_q;
  assign q_small  = quot < 63'(StoreDepth);
  assign q_n      = CW'(quot);
  assign pre_n    = q_n - CW'(1);
  assign pre_head = wrap_sub(head_q, q_n);

  // next values for the beat and outcome registers
  always_comb begin
    mode_d      = mode_q;
    t_d         = t_q;
    span_d      = span_q;
    val_d       = val_q;
    ow_d        = ow_q;
    do_write_d  = do_write_q;
    need_rd_d   = need_rd_q;
    fill_left_d = fill_left_q;
    new_count_d = new_count_q;
    new_head_d  = new_head_q;
    new_start_d = new_start_q;
    rv_d        = rv_q;
    flag_d      = flag_q;
    st_d        = st_q;
    wr_addr_d   = wr_addr_q;
    fill_addr_d = fill_addr_q;
    rd_addr_d   = rd_addr_q;
    if (cmd_i.load) begin
      mode_d = mode_i;
      t_d    = start_time_i;
      span_d = span_length_i;
      val_d  = sample_value_i;
      ow_d   = overwrite_enable_i;
    end
    if (cmd_i.decide) begin
      do_write_d  = 1'b0;
      need_rd_d   = 1'b0;
      fill_left_d = '0;
      new_count_d = count_q;
      new_head_d  = head_q;
      new_start_d = sstart_q;
      rv_d        = '0;
      flag_d      = 1'b0;
      st_d        = ST_OK;
      wr_addr_d   = wrap_add(head_q, count_q);
      fill_addr_d = wrap_add(head_q, count_q);
      rd_addr_d   = wrap_add(head_q, q_n);
      if (mode_q) begin
        if (count_q == '0) begin
          rv_d = marker_i; flag_d = 1'b1;
        end else if (rem != '0) begin
          st_d = ST_MISALIGN;
        end else if (!t_ge_start || !q_small || q_n >= count_q) begin
          rv_d = marker_i; flag_d = 1'b1;
        end else begin
          need_rd_d = 1'b1;
        end
      end else if (count_q == '0) begin
        if (span_q == '0) st_d = ST_PERIOD;
        else begin
          do_write_d = 1'b1; wr_addr_d = '0; new_head_d = '0;
          new_start_d = t_q; new_count_d = CW'(1);
        end
      end else if (span_q != period_q) begin
        st_d = ST_PERIOD;
      end else if ({1'b0, t_q} == end_w) begin
        if (room == '0) st_d = ST_FULL;
        else begin
          do_write_d = 1'b1; new_count_d = count_q + CW'(1);
        end
      end else if (rem != '0) begin
        st_d = ST_PHASE;
      end else if ({1'b0, t_q} > end_w) begin
        // quot - count gap slots
        if (!q_small || (q_n - count_q) >= room) st_d = ST_FULL;
        else begin
          do_write_d  = 1'b1;
          fill_left_d = q_n - count_q;
          wr_addr_d   = wrap_add(head_q, q_n);
          new_count_d = q_n + CW'(1);
        end
      end else if (!t_ge_start) begin
        // quot >= 1 here; gap is quot - 1
        if (!q_small || pre_n >= room) st_d = ST_FULL;
        else begin
          do_write_d  = 1'b1;
          fill_left_d = pre_n;
          wr_addr_d   = pre_head;
          fill_addr_d = wrap_add(pre_head, CW'(1));
          new_head_d  = pre_head;
          new_start_d = t_q;
          new_count_d = count_q + q_n;
        end
      end else if (ow_q) begin
        do_write_d = 1'b1;
        wr_addr_d  = wrap_add(head_q, q_n);
      end
    end
    if (cmd_i.fill_step) begin
      fill_addr_d = wrap_add(fill_addr_q, CW'(1));
      fill_left_d = fill_left_q - CW'(1);
    end
    if (cmd_i.rd_done) begin
      rv_d   = ram_rd;
      flag_d = ram_rd == marker_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    t_q         <= t_d;
    span_q      <= span_d;
    val_q       <= val_d;
    ow_q        <= ow_d;
    do_write_q  <= do_write_d;
    need_rd_q   <= need_rd_d;
    fill_left_q <= fill_left_d;
    new_count_q <= new_count_d;
    new_head_q  <= new_head_d;
    new_start_q <= new_start_d;
    rv_q        <= rv_d;
    flag_q      <= flag_d;
    st_q        <= st_d;
    wr_addr_q   <= wr_addr_d;
    fill_addr_q <= fill_addr_d;
    rd_addr_q   <= rd_addr_d;
  end

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      sstart_q <= '0;
      head_q   <= '0;
      count_q  <= '0;
    end else if (cmd_i.final_wr && do_write_q) begin
      if (count_q == '0) period_q <= span_q;
      sstart_q <= new_start_q;
      head_q   <= new_head_q;
      count_q  <= new_count_q;
    end
  end

  assign stat_o = '{div_busy: div_busy, is_read: mode_q,
                    fill_left: fill_left_q != '0, need_rd: need_rd_q,
                    do_write: do_write_q};
  assign read_value_o   = rv_q;
  assign missing_flag_o = flag_q;
  assign status_o       = st_q;
endmodule

// ===== hw/rtl/pss_ctrl.sv =====
// Controller: sequences division, gap fill, write or read, and result beat.
// Depends on pss_pkg.
module pss_ctrl
  import pss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pss_cmd_t  cmd_o,
  input  pss_stat_t stat_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV0 = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RDW  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; state_d = S_DIV0;
        end
      end
      S_DIV0: begin
        cmd_o.div_start = 1'b1; state_d = S_DIV;
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.decide = 1'b1; state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (stat_i.is_read) begin
          state_d = stat_i.need_rd ? S_RD : S_OUT;
        end else if (stat_i.fill_left) begin
          cmd_o.fill_step = 1'b1;
        end else begin
          cmd_o.final_wr = 1'b1; state_d = S_OUT;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1; state_d = S_RDW;
      end
      S_RDW: begin
        cmd_o.rd_done = 1'b1; state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule

// ===== hw/rtl/periodic_sample_store.sv =====
// Periodic sample store: one item at a time. Every item, insert or read,
// passes through the 63-step bit-serial offset divider before the outcome
// is decided and the result is offered. An append or prepend across a gap
// writes the missing slots one by one before the sample slot, and a read
// that fetches a slot goes through the registered RAM port. The result
// beat is held until taken.
// Depends on pss_pkg, pss_if, pss_ctrl, pss_datapath and the macro header.
`include "periodic_sample_store_macros.svh"
module periodic_sample_store
  import pss_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pss_if.sink   cfg,
  pss_if.sink   in_ch,
  pss_if.source out_ch
);
  logic [31:0] marker_q;
  pss_cmd_t    cmd;
  pss_stat_t   stat;

  // missing marker register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) marker_q <= MARKER_RESET;
    else if (cfg.valid) marker_q <= cfg.data.missing_marker;
  end

  pss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .cmd_o(cmd), .stat_i(stat)
  );

  pss_datapath #(.StoreDepth(STORE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .marker_i(marker_q),
    .mode_i(in_ch.data.mode), .start_time_i(in_ch.data.start_time),
    .span_length_i(in_ch.data.span_length),
    .sample_value_i(in_ch.data.sample_value),
    .overwrite_enable_i(in_ch.data.overwrite_enable),
    .read_value_o(out_ch.data.read_value),
    .missing_flag_o(out_ch.data.missing_flag),
    .status_o(out_ch.data.status)
  );

  `PSS_ASSERT(a_no_accept_busy, clk_i, rst_ni, out_ch.valid |-> !in_ch.ready)
  `PSS_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0(cmd))
  `PSS_ASSERT_NEVER(a_status_range, clk_i, rst_ni, out_ch.valid && out_ch.data.status > ST_FULL)
endmodule
